@@ design/mrcs_pkg.sv @@
// Shared widths, register indexes and result type for the row/column sum block.
package mrcs_pkg;

  // Fixed field widths
  localparam int SUM_W      = 24;
  localparam int IDX_OUT_W  = 8;
  localparam int ROWS_CFG_W = 9;
  localparam int COLS_CFG_W = 8;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

  // Saturation bounds of every sum
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // One result transaction
  typedef struct packed {
    logic                        is_column;
    logic [IDX_OUT_W-1:0]        index;
    logic signed [SUM_W-1:0]     sum;
  } result_t;

endpackage

@@ design/mrcs_in_if.sv @@
// Element channel: valid/ready handshake carrying one matrix element.
interface mrcs_in_if #(
  parameter int ELEMENT_WIDTH = 16
);
  logic                            valid;
  logic                            ready;
  logic signed [ELEMENT_WIDTH-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

@@ design/mrcs_out_if.sv @@
// Result channel: valid/ready handshake carrying the winning line.
interface mrcs_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   winner_is_column;
  logic [mrcs_pkg::IDX_OUT_W-1:0]         winner_index;
  logic signed [mrcs_pkg::SUM_W-1:0]      winner_sum;

  modport source (output valid, output winner_is_column, output winner_index,
                  output winner_sum, input ready);
  modport sink   (input valid, input winner_is_column, input winner_index,
                  input winner_sum, output ready);
endinterface

@@ design/max_row_or_column_sum.sv @@
// Top level: streams a matrix, keeps column sums in a memory, reports the best row or column.
//
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    element (ELEMENT_WIDTH, signed)
//  out_ch    out  valid / ready    winner_is_column, winner_index[7:0], winner_sum[23:0]
//  cfg_*     in   cfg_we only      cfg_index[0] (0 num_rows, 1 num_cols), cfg_wdata[8:0]
//
// One element is accepted per cycle while in_ch.ready is high. The column-sum memory is read
// when an element is accepted and written back in the following cycle; a write to the column
// being read in the same cycle is forwarded. The last element's result is pushed from stage 1.
// Reset is synchronous, clears the shape, positions and accumulators and empties the result buffer.
// The two-entry result buffer stalls input only when it is full, or holds one result
// while another is in flight and out_ch.ready is low.
module max_row_or_column_sum #(
  parameter int MAX_COLS      = 128,
  parameter int MAX_ROWS      = 256,
  parameter int ELEMENT_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mrcs_in_if.sink                           in_ch,
  mrcs_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [mrcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mrcs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SUM_W  = mrcs_pkg::SUM_W;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCMP_W = ($clog2(MAX_ROWS + 1) > mrcs_pkg::ROWS_CFG_W) ?
                          $clog2(MAX_ROWS + 1) : mrcs_pkg::ROWS_CFG_W;
  localparam int CCMP_W = ($clog2(MAX_COLS + 1) > mrcs_pkg::COLS_CFG_W) ?
                          $clog2(MAX_COLS + 1) : mrcs_pkg::COLS_CFG_W;
  localparam int XW     = (ELEMENT_WIDTH > SUM_W) ? ELEMENT_WIDTH : SUM_W;

  typedef logic signed [SUM_W-1:0] sum_t;

  // Saturating add into the sum range
  function automatic sum_t sat_add(input sum_t a, input sum_t b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? mrcs_pkg::SUM_MIN : mrcs_pkg::SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [ROW_W-1:0]  rows_last_r, rows_last_nxt;
  logic [COL_W-1:0]  cols_last_r, cols_last_nxt;
  logic [RCMP_W-1:0] rows_val;
  logic [CCMP_W-1:0] cols_val;

  // Clamp the written shape and keep its last index
  always_comb begin
    rows_last_nxt = rows_last_r;
    cols_last_nxt = cols_last_r;
    rows_val = RCMP_W'(cfg_wdata[mrcs_pkg::ROWS_CFG_W-1:0]);
    cols_val = CCMP_W'(cfg_wdata[mrcs_pkg::COLS_CFG_W-1:0]);
    if (cfg_we) begin
      unique case (cfg_index)
        mrcs_pkg::REG_NUM_ROWS: begin
          if (rows_val == '0) rows_last_nxt = '0;
          else if (rows_val > RCMP_W'(MAX_ROWS)) rows_last_nxt = ROW_W'(MAX_ROWS - 1);
          else rows_last_nxt = ROW_W'(rows_val - RCMP_W'(1));
        end
        mrcs_pkg::REG_NUM_COLS: begin
          if (cols_val == '0) cols_last_nxt = '0;
          else if (cols_val > CCMP_W'(MAX_COLS)) cols_last_nxt = COL_W'(MAX_COLS - 1);
          else cols_last_nxt = COL_W'(cols_val - CCMP_W'(1));
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 0: accept
  logic              in_acc;
  logic [ROW_W-1:0]  row_pos_r, row_pos_nxt;
  logic [COL_W-1:0]  col_pos_r, col_pos_nxt;
  logic              last_row, end_row;
  logic signed [XW-1:0] x_wide;
  sum_t              x_sat;

  logic [1:0]        out_cnt_r, out_cnt_nxt;
  logic              s1_valid_r, s1_res_r;
  logic              out_pop, out_push;

  // Accept while the result buffer can absorb every result in flight
  assign in_ch.ready = (out_cnt_r == 2'd0) ||
                       ((out_cnt_r == 2'd1) && (!(s1_valid_r && s1_res_r) || out_ch.ready));
  assign in_acc = in_ch.valid && in_ch.ready;

  assign last_row = (row_pos_r >= rows_last_r);
  assign end_row  = (col_pos_r >= cols_last_r);

  // Sign-extend the element, clamping into the sum range if wider
  always_comb begin
    x_wide = XW'(in_ch.element);
    if (x_wide > XW'(mrcs_pkg::SUM_MAX)) x_sat = mrcs_pkg::SUM_MAX;
    else if (x_wide < XW'(mrcs_pkg::SUM_MIN)) x_sat = mrcs_pkg::SUM_MIN;
    else x_sat = SUM_W'(x_wide);
  end

  // Advance row/column positions on each accepted element
  always_comb begin
    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r;
    if (in_acc) begin
      if (!end_row) begin
        col_pos_nxt = col_pos_r + COL_W'(1);
      end else begin
        col_pos_nxt = '0;
        row_pos_nxt = last_row ? '0 : row_pos_r + ROW_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- column memory
  sum_t              col_mem [MAX_COLS];
  sum_t              col_q_r;
  sum_t              csum;
  logic [COL_W-1:0]  s1_col_r;

  // Read at accept, write back from stage 1
  always_ff @(posedge clk) begin
    if (in_acc) begin
      col_q_r <= col_mem[col_pos_r];
    end
    if (s1_valid_r) begin
      col_mem[s1_col_r] <= csum;
    end
  end

  // ---------------------------------------------------------------- stage 1: update
  sum_t              s1_x_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic              s1_first_r, s1_last_r, s1_end_r;
  logic              fwd_hit_r, fwd_hit_nxt;
  sum_t              fwd_data_r;

  sum_t              row_acc_r, row_acc_nxt, acc_sum, col_rd;
  sum_t              best_row_sum_r, best_row_sum_nxt;
  logic [ROW_W-1:0]  best_row_idx_r, best_row_idx_nxt;
  sum_t              best_col_sum_r, best_col_sum_nxt;
  logic [COL_W-1:0]  best_col_idx_r, best_col_idx_nxt;
  mrcs_pkg::result_t res_nxt;

  // Forward when the write-back hits the column being read in the same cycle
  assign fwd_hit_nxt = in_acc && s1_valid_r && (s1_col_r == col_pos_r);

  assign col_rd  = fwd_hit_r ? fwd_data_r : col_q_r;
  assign acc_sum = sat_add(row_acc_r, s1_x_r);
  assign csum    = s1_first_r ? s1_x_r : sat_add(col_rd, s1_x_r);

  // Update row accumulator and best row/column
  always_comb begin
    row_acc_nxt      = row_acc_r;
    best_row_sum_nxt = best_row_sum_r;
    best_row_idx_nxt = best_row_idx_r;
    best_col_sum_nxt = best_col_sum_r;
    best_col_idx_nxt = best_col_idx_r;
    if (s1_valid_r) begin
      row_acc_nxt = s1_end_r ? '0 : acc_sum;
      if (s1_last_r && ((s1_col_r == '0) || (csum > best_col_sum_r))) begin
        best_col_sum_nxt = csum;
        best_col_idx_nxt = s1_col_r;
      end
      if (s1_end_r && (s1_first_r || (acc_sum > best_row_sum_r))) begin
        best_row_sum_nxt = acc_sum;
        best_row_idx_nxt = s1_row_r;
      end
    end
  end

  // Pick the winner once the matrix closes
  always_comb begin
    if (best_row_sum_nxt >= best_col_sum_nxt) begin
      res_nxt.is_column = 1'b0;
      res_nxt.index     = mrcs_pkg::IDX_OUT_W'(best_row_idx_nxt);
      res_nxt.sum       = best_row_sum_nxt;
    end else begin
      res_nxt.is_column = 1'b1;
      res_nxt.index     = mrcs_pkg::IDX_OUT_W'(best_col_idx_nxt);
      res_nxt.sum       = best_col_sum_nxt;
    end
  end

  // ---------------------------------------------------------------- result buffer
  mrcs_pkg::result_t res_buf_r [2];
  logic              wr_slot;

  assign out_pop     = out_ch.valid && out_ch.ready;
  assign out_push    = s1_valid_r && s1_res_r;
  assign out_cnt_nxt = out_cnt_r + {1'b0, out_push} - {1'b0, out_pop};
  assign wr_slot     = out_pop ? 1'b0 : out_cnt_r[0];

  // Load the free slot on push, otherwise shift the head on pop
  always_ff @(posedge clk) begin
    if (out_push && !wr_slot) begin
      res_buf_r[0] <= res_nxt;
    end else if (out_pop) begin
      res_buf_r[0] <= res_buf_r[1];
    end
    if (out_push && wr_slot) begin
      res_buf_r[1] <= res_nxt;
    end
  end

  assign out_ch.valid            = (out_cnt_r != 2'd0);
  assign out_ch.winner_is_column = res_buf_r[0].is_column;
  assign out_ch.winner_index     = res_buf_r[0].index;
  assign out_ch.winner_sum       = res_buf_r[0].sum;

  // ---------------------------------------------------------------- registers
  // Stage-1 payload and forwarding data
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r     <= x_sat;
      s1_col_r   <= col_pos_r;
      s1_row_r   <= row_pos_r;
      s1_first_r <= (row_pos_r == '0);
      s1_last_r  <= last_row;
      s1_end_r   <= end_row;
    end
    fwd_data_r <= csum;
  end

  // Control and running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_last_r    <= '0;
      cols_last_r    <= '0;
      row_pos_r      <= '0;
      col_pos_r      <= '0;
      s1_valid_r     <= 1'b0;
      s1_res_r       <= 1'b0;
      fwd_hit_r      <= 1'b0;
      row_acc_r      <= '0;
      best_row_sum_r <= '0;
      best_row_idx_r <= '0;
      best_col_sum_r <= '0;
      best_col_idx_r <= '0;
      out_cnt_r      <= 2'd0;
    end else begin
      rows_last_r    <= rows_last_nxt;
      cols_last_r    <= cols_last_nxt;
      row_pos_r      <= row_pos_nxt;
      col_pos_r      <= col_pos_nxt;
      s1_valid_r     <= in_acc;
      s1_res_r       <= in_acc && last_row && end_row;
      fwd_hit_r      <= fwd_hit_nxt;
      row_acc_r      <= row_acc_nxt;
      best_row_sum_r <= best_row_sum_nxt;
      best_row_idx_r <= best_row_idx_nxt;
      best_col_sum_r <= best_col_sum_nxt;
      best_col_idx_r <= best_col_idx_nxt;
      out_cnt_r      <= out_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------- assertions
  a_no_buf_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_push && !out_pop |-> (out_cnt_r != 2'd2))
    else $error("result buffer overflow");

  a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_cnt_r == 2'd2) |-> !in_ch.ready)
    else $error("input accepted while result buffer full");

  a_fwd_same_column: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> (s1_valid_r && $past(s1_valid_r) && (s1_col_r == $past(s1_col_r))))
    else $error("forwarding from a different column");

endmodule
